[rtl/core/bdhl_pkg.sv]
// Package for the 5x5 Bayer demosaic: register indexes, widths, and the
// token type passed from the window front end to the filter back end.
package bdhl_pkg;
	localparam int PIX_W = 8;
	localparam int CFG_W = 12;
	localparam int COORD_W = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_Y = 2'd3;

	// Input and result transactions as seen on the top level's channels.
	typedef struct packed {
		logic [PIX_W-1:0] raw_pixel;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0]   chan_w;
		logic [PIX_W-1:0]   chan_x;
		logic [PIX_W-1:0]   chan_y;
		logic               chan_z;
		logic [COORD_W-1:0] out_col;
		logic [COORD_W-1:0] out_row;
	} out_item_t;

	// Window samples needed by the filters plus phase and position.
	typedef struct packed {
		logic [PIX_W-1:0] l2, r2, u2, d2, l1, r1, u1, d1;
		logic [PIX_W-1:0] ul, ur, dl, dr, ctr;
		logic             px;
		logic             py;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} win_tok_t;

	typedef struct packed {
		logic [PIX_W-1:0]   w;
		logic [PIX_W-1:0]   x;
		logic [PIX_W-1:0]   y;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pix_out_t;

	function automatic logic [PIX_W-1:0] clamp16(input logic signed [15:0] f);
		logic [PIX_W-1:0] r;
		if (f <= 0) r = '0;
		else if (f >= 16'sd4080) r = 8'hFF;
		else r = f[11:4];
		return r;
	endfunction
endpackage

[rtl/core/bdhl_stream_if.sv]
// Valid/ready stream interface with a generic payload type.
// Depends on nothing; payload type comes in as a type parameter.
interface bdhl_stream_if #(parameter type T = logic [7:0]);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/core/bdhl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bdhl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

[rtl/core/bdhl_front.sv]
// Front end: line stores, counters and the 5x5 window; emits one token per
// interior center. Depends on bdhl_pkg and bdhl_ram.
module bdhl_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bdhl_pkg::PIX_W-1:0]  in_pixel,
	input  logic [bdhl_pkg::CFG_W-1:0]  width_q,
	input  logic [bdhl_pkg::CFG_W-1:0]  height_q,
	input  logic                        phase_x_q,
	input  logic                        phase_y_q,
	output logic                        tok_valid,
	input  logic                        tok_ready,
	output bdhl_pkg::win_tok_t          tok
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int LW = 4 * bdhl_pkg::PIX_W;

	logic [CW-1:0] col_q, w_eff;
	logic [RW-1:0] row_q, h_eff;
	logic          acc;
	// stage 1: RAM read in flight
	logic          v_s1, emit_s1, adv;
	logic [bdhl_pkg::PIX_W-1:0] pix_s1;
	logic [AW-1:0] addr_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [LW-1:0] rd;
	logic [bdhl_pkg::PIX_W-1:0] win_q [5][5];
	logic [bdhl_pkg::PIX_W-1:0] column [5];
	logic [CW-1:0] cx;
	logic [RW-1:0] cy;
	logic [LW-1:0] rd_fw;
	logic          fw_q;
	logic [LW-1:0] wd_q;

	always_comb begin
		if (width_q < 12'd5) w_eff = CW'(5);
		else if (int'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
		else w_eff = CW'(width_q);
		if (height_q < 12'd5) h_eff = RW'(5);
		else if (int'(height_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
		else h_eff = RW'(height_q);
	end

	// Stage 1 holds while its token cannot be loaded; the input waits behind it.
	assign adv = v_s1 && (!emit_s1 || !tok_valid || tok_ready);
	assign in_ready = !v_s1 || adv;
	assign acc = in_valid && in_ready;

	bdhl_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
		.clk(clk), .we(adv), .waddr(addr_s1),
		.wdata({pix_s1, rd[LW-1:bdhl_pkg::PIX_W]}),
		.re(acc), .raddr(col_q[AW-1:0]), .rdata(rd));

	// A write to the column being read in the same cycle: forward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fw_q <= 1'b0;
		else if (acc) fw_q <= v_s1 && (addr_s1 == col_q[AW-1:0]);
		else if (adv) fw_q <= 1'b0;
	end
	always_ff @(posedge clk) if (acc) wd_q <= {pix_s1, rd_fw[LW-1:bdhl_pkg::PIX_W]};
	assign rd_fw = fw_q ? wd_q : rd;

	always_comb begin
		for (int r = 0; r < 4; r++) column[r] = rd_fw[r*bdhl_pkg::PIX_W +: bdhl_pkg::PIX_W];
		column[4] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
			tok_valid <= 1'b0;
			for (int r = 0; r < 5; r++)
				for (int c = 0; c < 5; c++) win_q[r][c] <= '0;
		end else begin
			tok_valid <= (adv && emit_s1) || (tok_valid && !tok_ready);
			if (adv) begin
				for (int r = 0; r < 5; r++) begin
					for (int c = 0; c < 4; c++) win_q[r][c] <= win_q[r][c+1];
					win_q[r][4] <= column[r];
				end
			end
			v_s1 <= acc || (v_s1 && !adv);
			if (acc) begin
				if (col_q + 1'b1 >= w_eff) begin
					col_q <= '0;
					row_q <= (row_q + 1'b1 >= h_eff) ? '0 : row_q + 1'b1;
				end else col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1 <= in_pixel;
			addr_s1 <= col_q[AW-1:0];
			col_s1 <= col_q;
			row_s1 <= row_q;
			emit_s1 <= (col_q >= CW'(4)) && (row_q >= RW'(4));
		end
	end

	// Token is built from the window as it stands after the shift.
	assign cx = col_s1 - CW'(2);
	assign cy = row_s1 - RW'(2);
	always_ff @(posedge clk) begin
		if (adv && emit_s1) begin
			tok.l2 <= win_q[2][1]; tok.r2 <= column[2];
			tok.u2 <= win_q[0][3]; tok.d2 <= win_q[4][3];
			tok.l1 <= win_q[2][2]; tok.r1 <= win_q[2][4];
			tok.u1 <= win_q[1][3]; tok.d1 <= win_q[3][3];
			tok.ul <= win_q[1][2]; tok.ur <= win_q[1][4];
			tok.dl <= win_q[3][2]; tok.dr <= win_q[3][4];
			tok.ctr <= win_q[2][3];
			tok.px <= cx[0] ^ phase_x_q;
			tok.py <= cy[0] ^ phase_y_q;
			tok.col <= bdhl_pkg::COORD_W'(cx);
			tok.row <= bdhl_pkg::COORD_W'(cy);
		end
	end
endmodule

[rtl/core/bdhl_fifo.sv]
// Two-entry queue between front and back ends.
// Depends on bdhl_pkg.
module bdhl_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bdhl_pkg::win_tok_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bdhl_pkg::win_tok_t out_data
);
	bdhl_pkg::win_tok_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
	always_ff @(posedge clk) if (push) mem_q[wp_q] <= in_data;
endmodule

[rtl/core/bdhl_back.sv]
// Back end: neighbor sums, the four filters, clamping and channel routing.
// Depends on bdhl_pkg.
module bdhl_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bdhl_pkg::win_tok_t tok,
	output logic               out_valid,
	input  logic               out_ready,
	output bdhl_pkg::pix_out_t res
);
	typedef logic signed [15:0] s16_t;
	s16_t s1, s2, s3, s4, s5, s6, fa, fb, fc, fd;
	logic [7:0] a, b, c, d, ctr;

	assign in_ready = !out_valid || out_ready;

	always_comb begin
		s1 = s16_t'(tok.l2) + s16_t'(tok.r2);
		s2 = s16_t'(tok.u2) + s16_t'(tok.d2);
		s3 = s16_t'(tok.l1) + s16_t'(tok.r1);
		s4 = s16_t'(tok.u1) + s16_t'(tok.d1);
		s5 = s16_t'(tok.ul) + s16_t'(tok.ur) + s16_t'(tok.dl) + s16_t'(tok.dr);
		s6 = s16_t'(tok.ctr);
		fa = -(s1 <<< 1) - (s2 <<< 1) + (s3 <<< 2) + (s4 <<< 2) + (s6 <<< 3);
		fb = -(s1 <<< 1) + s2 + (s3 <<< 3) - (s5 <<< 1) + (s6 <<< 3) + (s6 <<< 1);
		fc = s1 - (s2 <<< 1) + (s4 <<< 3) - (s5 <<< 1) + (s6 <<< 3) + (s6 <<< 1);
		fd = -(s1 + (s1 <<< 1)) - (s2 + (s2 <<< 1)) + (s5 <<< 2) + (s6 <<< 3)
			+ (s6 <<< 2);
		a = bdhl_pkg::clamp16(fa);
		b = bdhl_pkg::clamp16(fb);
		c = bdhl_pkg::clamp16(fc);
		d = bdhl_pkg::clamp16(fd);
		ctr = tok.ctr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (in_ready) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			case ({tok.py, tok.px})
				2'b00: begin res.w <= ctr; res.x <= a; res.y <= d; end
				2'b01: begin res.w <= b; res.x <= ctr; res.y <= c; end
				2'b10: begin res.w <= c; res.x <= ctr; res.y <= b; end
				default: begin res.w <= d; res.x <= a; res.y <= ctr; end
			endcase
			res.col <= tok.col;
			res.row <= tok.row;
		end
	end
endmodule

[rtl/core/bayer_demosaic_hq_linear_top.sv]
// Path from an accepted pixel to its result: RAM read, token, queue, filter.
// Throughput: one pixel per cycle unless the output stalls; line-store RAM does one read and one write per cycle.
// Border centers give no result. Reset (arst_n low, async) clears counters, window,
// queue and registers to 2048/2048/0/0; line-store contents are undefined until written.
// Depends on bdhl_pkg, bdhl_stream_if, bdhl_front, bdhl_fifo, bdhl_back.
module bayer_demosaic_hq_linear_top #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                              clk,
	input  logic                              arst_n,
	bdhl_stream_if.sink                       pix_in,
	bdhl_stream_if.source                     pix_out,
	input  logic                              cfg_we,
	input  logic [bdhl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdhl_pkg::CFG_W-1:0]        cfg_data
);
	logic [bdhl_pkg::CFG_W-1:0] width_q, height_q;
	logic phase_x_q, phase_y_q;
	logic f_valid, f_ready, q_valid, q_ready;
	bdhl_pkg::win_tok_t f_tok, q_tok;
	bdhl_pkg::pix_out_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd2048;
			height_q <= 12'd2048;
			phase_x_q <= 1'b0;
			phase_y_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				bdhl_pkg::REG_WIDTH: width_q <= cfg_data;
				bdhl_pkg::REG_HEIGHT: height_q <= cfg_data;
				bdhl_pkg::REG_PHASE_X: phase_x_q <= cfg_data[0];
				bdhl_pkg::REG_PHASE_Y: phase_y_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bdhl_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .in_valid(pix_in.valid), .in_ready(pix_in.ready),
		.in_pixel(pix_in.data.raw_pixel), .width_q, .height_q, .phase_x_q, .phase_y_q,
		.tok_valid(f_valid), .tok_ready(f_ready), .tok(f_tok));

	bdhl_fifo u_fifo (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_tok),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_tok));

	bdhl_back u_back (
		.clk, .arst_n, .in_valid(q_valid), .in_ready(q_ready), .tok(q_tok),
		.out_valid(pix_out.valid), .out_ready(pix_out.ready), .res(res));

	assign pix_out.data.chan_w = res.w;
	assign pix_out.data.chan_x = res.x;
	assign pix_out.data.chan_y = res.y;
	assign pix_out.data.chan_z = 1'b0;
	assign pix_out.data.out_col = res.col;
	assign pix_out.data.out_row = res.row;
endmodule

[rtl/core/bdhl_checker.sv]
// Port-level checker for the demosaic top level, bound in below.
// Depends on bdhl_pkg only through the top level's ports.
module bdhl_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic chan_z,
	input logic [10:0] out_col,
	input logic [10:0] out_row
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(out_row))
		else $error("result dropped under stall");
	a_z: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> chan_z == 1'b0) else $error("chan_z nonzero");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid) else $error("result out of reset");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(!out_valid) && $past(!out_valid, 2) |-> in_ready)
		else $error("input stalled with empty output");
endmodule

bind bayer_demosaic_hq_linear_top bdhl_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(pix_in.valid), .in_ready(pix_in.ready),
	.out_valid(pix_out.valid), .out_ready(pix_out.ready), .chan_z(pix_out.data.chan_z),
	.out_col(pix_out.data.out_col), .out_row(pix_out.data.out_row));

[tb/tb_bayer_demosaic_hq_linear_top.sv]
// Testbench for the 5x5 Bayer demosaic top: random frames in raster order,
// with a scoreboard that predicts each filtered pixel and checks it.
// Depends on bdhl_pkg, bdhl_stream_if and bayer_demosaic_hq_linear_top.
module tb_bayer_demosaic_hq_linear_top;
	localparam int LINE_MAX = 2048;
	localparam int CYCLE_LIMIT = 600000;

	typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_CHECKER, FILL_FLAT} fill_t;

	// Predicts the demosaiced pixels and holds those not yet seen at the output.
	class demosaic_scoreboard;
		logic [bdhl_pkg::PIX_W-1:0] lines[4][LINE_MAX];
		logic [bdhl_pkg::PIX_W-1:0] win[5][5];
		int col, row;
		logic [bdhl_pkg::CFG_W-1:0] width, height;
		logic phx, phy;
		bdhl_pkg::out_item_t pending[$];
		int errors, checked, accepted;

		function new();
			width = 12'd2048;
			height = 12'd2048;
			phx = 0;
			phy = 0;
			col = 0;
			row = 0;
			foreach (win[r, c]) win[r][c] = '0;
		endfunction

		function void set_reg(logic [bdhl_pkg::CFG_IDX_W-1:0] idx,
				logic [bdhl_pkg::CFG_W-1:0] val);
			case (idx)
				bdhl_pkg::REG_WIDTH: width = val;
				bdhl_pkg::REG_HEIGHT: height = val;
				bdhl_pkg::REG_PHASE_X: phx = val[0];
				bdhl_pkg::REG_PHASE_Y: phy = val[0];
				default: ;
			endcase
		endfunction

		function int eff_size(logic [bdhl_pkg::CFG_W-1:0] v, int hi);
			if (v < 5) return 5;
			if (v > hi) return hi;
			return v;
		endfunction

		function logic [bdhl_pkg::PIX_W-1:0] sat16(int f);
			if (f <= 0) return '0;
			if (f >= 4080) return 8'hFF;
			return f[11:4];
		endfunction

		function void note_input(logic [bdhl_pkg::PIX_W-1:0] p);
			logic [bdhl_pkg::PIX_W-1:0] column[5];
			int s1, s2, s3, s4, s5, s6, w, h;
			logic [bdhl_pkg::PIX_W-1:0] fa, fb, fc, fd, ctr;
			bdhl_pkg::out_item_t e;
			w = eff_size(width, LINE_MAX);
			h = eff_size(height, LINE_MAX);
			accepted++;
			for (int r = 0; r < 4; r++) column[r] = lines[r][col];
			column[4] = p;
			for (int r = 0; r < 3; r++) lines[r][col] = lines[r + 1][col];
			lines[3][col] = p;
			for (int r = 0; r < 5; r++) begin
				for (int c = 0; c < 4; c++) win[r][c] = win[r][c + 1];
				win[r][4] = column[r];
			end
			if (col >= 4 && row >= 4) begin
				s1 = win[2][0] + win[2][4];
				s2 = win[0][2] + win[4][2];
				s3 = win[2][1] + win[2][3];
				s4 = win[1][2] + win[3][2];
				s5 = win[1][1] + win[1][3] + win[3][1] + win[3][3];
				s6 = win[2][2];
				fa = sat16(-2 * s1 - 2 * s2 + 4 * s3 + 4 * s4 + 8 * s6);
				fb = sat16(-2 * s1 + s2 + 8 * s3 - 2 * s5 + 10 * s6);
				fc = sat16(s1 - 2 * s2 + 8 * s4 - 2 * s5 + 10 * s6);
				fd = sat16(-3 * s1 - 3 * s2 + 4 * s5 + 12 * s6);
				ctr = win[2][2];
				e.out_col = bdhl_pkg::COORD_W'(col - 2);
				e.out_row = bdhl_pkg::COORD_W'(row - 2);
				e.chan_z = 1'b0;
				case ({(e.out_row[0] ^ phy), (e.out_col[0] ^ phx)})
					2'b00: begin e.chan_w = ctr; e.chan_x = fa; e.chan_y = fd; end
					2'b01: begin e.chan_w = fb; e.chan_x = ctr; e.chan_y = fc; end
					2'b10: begin e.chan_w = fc; e.chan_x = ctr; e.chan_y = fb; end
					default: begin e.chan_w = fd; e.chan_x = fa; e.chan_y = ctr; end
				endcase
				pending.push_back(e);
			end
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void check(bdhl_pkg::out_item_t got);
			bdhl_pkg::out_item_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected output pixel %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.chan_w !== e.chan_w) begin
				$display("%0t: chan_w expected %0d actual %0d", $time, e.chan_w, got.chan_w);
				errors++;
			end
			if (got.chan_x !== e.chan_x) begin
				$display("%0t: chan_x expected %0d actual %0d", $time, e.chan_x, got.chan_x);
				errors++;
			end
			if (got.chan_y !== e.chan_y) begin
				$display("%0t: chan_y expected %0d actual %0d", $time, e.chan_y, got.chan_y);
				errors++;
			end
			if (got.chan_z !== e.chan_z) begin
				$display("%0t: chan_z expected %0d actual %0d", $time, e.chan_z, got.chan_z);
				errors++;
			end
			if (got.out_col !== e.out_col) begin
				$display("%0t: out_col expected %0d actual %0d", $time, e.out_col,
					got.out_col);
				errors++;
			end
			if (got.out_row !== e.out_row) begin
				$display("%0t: out_row expected %0d actual %0d", $time, e.out_row,
					got.out_row);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [bdhl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [bdhl_pkg::CFG_W-1:0] cfg_data = '0;
	bit idle_on = 1;
	int hold_cycles = 0;
	int cycles = 0;
	int frames = 0;
	demosaic_scoreboard sb = new();

	bdhl_stream_if #(.T(bdhl_pkg::in_item_t)) pix_in_if();
	bdhl_stream_if #(.T(bdhl_pkg::out_item_t)) pix_out_if();

	bayer_demosaic_hq_linear_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in_if),
		.pix_out(pix_out_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	initial begin
		pix_in_if.valid = 0;
		pix_in_if.data = '0;
	end

	// Output side: check every transaction, then pick ready for the next edge.
	initial begin
		pix_out_if.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && pix_out_if.valid && pix_out_if.ready) sb.check(pix_out_if.data);
			if (hold_cycles > 0) begin
				hold_cycles--;
				pix_out_if.ready <= 0;
			end else begin
				pix_out_if.ready <= !(idle_on && $urandom_range(99) < 20);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("bayer_demosaic_hq_linear_top test failed");
			$finish;
		end
	end

	task automatic send_pixel(input logic [7:0] p);
		while (idle_on && $urandom_range(99) < 20) begin
			pix_in_if.valid <= 0;
			@(posedge clk);
		end
		pix_in_if.valid <= 1;
		pix_in_if.data.raw_pixel <= p;
		do @(posedge clk); while (!pix_in_if.ready);
		sb.note_input(p);
	endtask

	task automatic drain();
		pix_in_if.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// All four registers in one burst, while the block is idle.
	task automatic configure(input logic [bdhl_pkg::CFG_W-1:0] w,
			input logic [bdhl_pkg::CFG_W-1:0] h, input bit px, input bit py);
		logic [bdhl_pkg::CFG_W-1:0] vals[4];
		vals = '{w, h, {11'd0, px}, {11'd0, py}};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1;
			cfg_index <= bdhl_pkg::CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(bdhl_pkg::CFG_IDX_W'(i), vals[i]);
		end
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_frame(input int w, input int h, input fill_t fill);
		logic [7:0] p;
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++) begin
				case (fill)
					FILL_EXTREME: p = $urandom_range(1) ? 8'hFF : 8'h00;
					FILL_CHECKER: p = ((r + c) & 1) ? 8'hFF : 8'h00;
					FILL_FLAT: p = 8'hFF;
					default: p = 8'($urandom_range(255));
				endcase
				send_pixel(p);
			end
		frames++;
	endtask

	initial begin
		int w, h;
		fill_t fill;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: undersized registers saturate to 5x5; flat white and checkerboard.
		configure(12'd0, 12'd0, 0, 0);
		send_frame(5, 5, FILL_FLAT);
		drain();
		configure(12'd5, 12'd5, 1, 1);
		send_frame(5, 5, FILL_CHECKER);
		drain();

		while (sb.accepted < 1400) begin
			w = $urandom_range(12, 5);
			h = $urandom_range(10, 5);
			fill = ($urandom_range(9) < 7) ? FILL_RANDOM : FILL_EXTREME;
			configure(bdhl_pkg::CFG_W'(w), bdhl_pkg::CFG_W'(h), 1'($urandom_range(1)),
				1'($urandom_range(1)));
			if (frames == 4) idle_on = 0;
			if (frames == 8) idle_on = 1;
			if (frames == 10) hold_cycles = 300;
			send_frame(w, h, fill);
			if (frames % 5 == 0) begin
				drain();
				repeat ($urandom_range(20)) @(posedge clk);
			end else begin
				drain();
			end
		end

		drain();
		$display("%0d frames, %0d pixels in, %0d filtered pixels checked",
			frames, sb.accepted, sb.checked);
		$display("sizes 5..12 x 5..10, saturated small sizes, all four Bayer phases");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("bayer_demosaic_hq_linear_top test passed");
		end else begin
			$display("bayer_demosaic_hq_linear_top test failed");
		end
		$finish;
	end
endmodule
